// File: hw/rtl/efws_pkg.sv
// ---------------------------------------------------------------------------
// efws_pkg
// Shared widths, constants, cell control type and time arithmetic for the
// earliest-free worker scheduler.
// ---------------------------------------------------------------------------
package efws_pkg;

   localparam int TIME_W   = 48;
   localparam int DUR_W    = 32;
   localparam int WORKER_W = 4;
   localparam int CSR_W    = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic clear;
      logic update;
   } cell_ctrl_type;

   // finish time after a job, saturating at the largest time value
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] start,
                                                  input logic [DUR_W-1:0] dur);
      logic [TIME_W:0] sum;
      sum = {1'b0, start} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

endpackage

// File: hw/rtl/efws_cell.sv
// ---------------------------------------------------------------------------
// efws_cell
// One slot of the sorted chain: holds a (finish time, worker) entry and on
// update takes its right neighbor's entry, the inserted key, or keeps its own.
// ---------------------------------------------------------------------------
module efws_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  efws_pkg::cell_ctrl_type       ctrl,
   input  logic                          active,
   input  logic [efws_pkg::TIME_W-1:0]   key_time,
   input  logic [IDX_W-1:0]              key_idx,
   input  logic                          nb_lt,
   input  logic [efws_pkg::TIME_W-1:0]   nb_time,
   input  logic [IDX_W-1:0]              nb_idx,
   output logic                          lt,
   output logic [efws_pkg::TIME_W-1:0]   time_out,
   output logic [IDX_W-1:0]              idx_out
);

   localparam logic FIRST = (CELL_IDX == 0);

   logic [efws_pkg::TIME_W-1:0] time_ff, time_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;

   // worker index breaks ties, so keys never compare equal
   assign lt       = active && ({time_ff, idx_ff} < {key_time, key_idx});
   assign time_out = time_ff;
   assign idx_out  = idx_ff;

   always_comb begin
      time_in = time_ff;
      idx_in  = idx_ff;
      if (ctrl.clear) begin
         time_in = '0;
         idx_in  = IDX_W'(CELL_IDX);
      end else if (ctrl.update) begin
         if (nb_lt) begin
            time_in = nb_time;
            idx_in  = nb_idx;
         end else if (FIRST || lt) begin
            time_in = key_time;
            idx_in  = key_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         idx_ff  <= IDX_W'(CELL_IDX);
      end else begin
         time_ff <= time_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

// File: hw/rtl/earliest_free_worker_scheduler_top.sv
// A result is registered and valid in the cycle after its request is accepted.
// Requests are not taken while the chain reinserts the updated entry, which it
// does in the cycle after the head is taken, nor while a result is not accepted.
// Reset (synchronous, active high): 16 workers in use (at most MAX_WORKERS),
// all free at time zero; a worker count write clears the chain the same way.
// ---------------------------------------------------------------------------
// earliest_free_worker_scheduler_top
// Assigns each job to the worker that is free first, using a sorted chain of
// (finish time, worker) cells whose head is always the earliest worker.
// ---------------------------------------------------------------------------
module earliest_free_worker_scheduler_top #(
   parameter int MAX_WORKERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,     // [4:0] worker_count
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] job_duration
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata     // [3:0] worker, [51:4] start_time
);

   localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
   localparam int RESET_COUNT = (MAX_WORKERS < 16) ? MAX_WORKERS : 16;
   localparam int TW          = efws_pkg::TIME_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff;
   logic              rsp_valid_ff;
   logic [TW-1:0]     rsp_start_ff;
   logic [efws_pkg::WORKER_W-1:0] rsp_worker_ff;
   logic [TW-1:0]     key_time_ff;
   logic [IDX_W-1:0]  key_idx_ff;

   logic [MAX_WORKERS-1:0] active;
   logic [MAX_WORKERS-1:0] lt;
   logic [TW-1:0]          cell_time [MAX_WORKERS];
   logic [IDX_W-1:0]       cell_idx  [MAX_WORKERS];

   efws_pkg::cell_ctrl_type ctrl;

   logic        req_fire, csr_fire;
   logic [31:0] head_idx_ext;
   logic [efws_pkg::CSR_W-1:0] csr_value;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign csr_value  = csr_data[efws_pkg::CSR_W-1:0];
   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_start_ff, rsp_worker_ff};

   assign head_idx_ext = 32'(cell_idx[0]);

   assign ctrl.clear  = csr_fire;
   assign ctrl.update = busy_ff;

   // clamp written worker count to 1..MAX_WORKERS
   always_comb begin
      if (csr_value == '0) begin
         count_in = CNT_W'(1);
      end else if (int'(csr_value) > MAX_WORKERS) begin
         count_in = CNT_W'(MAX_WORKERS);
      end else begin
         count_in = CNT_W'(csr_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(RESET_COUNT);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            count_ff <= count_in;
         end
         busy_ff <= req_fire;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // head of the chain is the earliest free worker
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_start_ff  <= cell_time[0];
         rsp_worker_ff <= head_idx_ext[efws_pkg::WORKER_W-1:0];
         key_time_ff   <= efws_pkg::sat_add(cell_time[0], req_tdata);
         key_idx_ff    <= cell_idx[0];
      end
   end

   for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
      logic          nb_lt;
      logic [TW-1:0] nb_time;
      logic [IDX_W-1:0] nb_idx;

      assign active[i] = (CNT_W'(i) < count_ff);

      if (i == MAX_WORKERS - 1) begin : g_last
         assign nb_lt   = 1'b0;
         assign nb_time = '0;
         assign nb_idx  = '0;
      end else begin : g_mid
         assign nb_lt   = lt[i+1];
         assign nb_time = cell_time[i+1];
         assign nb_idx  = cell_idx[i+1];
      end

      efws_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .active   (active[i]),
         .key_time (key_time_ff),
         .key_idx  (key_idx_ff),
         .nb_lt    (nb_lt),
         .nb_time  (nb_time),
         .nb_idx   (nb_idx),
         .lt       (lt[i]),
         .time_out (cell_time[i]),
         .idx_out  (cell_idx[i])
      );
   end

endmodule
